/* sv/cia_pkg.sv */
package cia_pkg;

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_REM = 4'd4;
    localparam logic [3:0] MODE_SHL = 4'd5;
    localparam logic [3:0] MODE_SHR = 4'd6;
    localparam logic [3:0] MODE_AND = 4'd7;
    localparam logic [3:0] MODE_OR  = 4'd8;
    localparam logic [3:0] MODE_LT  = 4'd9;
    localparam logic [3:0] MODE_GT  = 4'd10;
    localparam logic [3:0] MODE_NE  = 4'd11;
    localparam logic [3:0] MODE_EQ  = 4'd12;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_OVF  = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] a;
        logic [63:0] b;
    } op_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  err;
    } res_t;

endpackage

/* sv/cia_queue.sv */
module cia_queue #(
    parameter int WIDTH = 132
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    wire push = in_valid && in_ready;
    wire pop  = out_valid && out_ready;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 && !out_ready |=> count_reg == 2'd2)
        else $error("queue lost an item while full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && count_reg == 2'd0 |=> out_valid)
        else $error("pushed item not visible");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

/* sv/cia_front.sv */
module cia_front #(
    parameter int DATA_WIDTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [3:0]    in_mode,
    input  logic [63:0]   in_a,
    input  logic [63:0]   in_b,
    output logic          out_valid,
    input  logic          out_ready,
    output cia_pkg::op_t  out_op
);

    cia_pkg::op_t op_reg;
    logic         valid_reg;

    function automatic logic [63:0] sx(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int i = DATA_WIDTH; i < 64; i++) begin
            r[i] = v[DATA_WIDTH-1];
        end
        return r;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_op    = op_reg;

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg.mode <= in_mode;
            op_reg.a    <= sx(in_a);
            op_reg.b    <= sx(in_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

endmodule

/* sv/cia_divider.sv */
module cia_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic        done,
    output logic [63:0] quo,
    output logic [63:0] rmd
);

    logic [63:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;

    assign trial = {r_reg, q_reg[63]} - {1'b0, d_reg};
    assign busy  = busy_reg;
    assign done  = done_reg;
    assign quo   = q_reg;
    assign rmd   = r_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= num;
            r_reg <= 64'd0;
            d_reg <= den;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                r_reg <= trial[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                r_reg <= {r_reg[62:0], q_reg[63]};
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* sv/cia_back.sv */
module cia_back #(
    parameter int DATA_WIDTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cia_pkg::op_t  in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output cia_pkg::res_t out_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [63:0] HALF = 64'd1 << (DATA_WIDTH - 1);

    logic [1:0]    st_reg;
    cia_pkg::op_t  op_reg;
    cia_pkg::res_t res_reg;
    logic          ovalid_reg;
    logic [63:0]   ma_reg, mb_reg;
    logic          neg_reg;
    logic [1:0]    mstep_reg;
    logic [63:0]   pp_reg [4];
    logic          div_start;
    logic          div_busy, div_done;
    logic [63:0]   div_q, div_r;
    logic          res_load;

    logic [63:0]   a, b, ma, mb;
    logic [63:0]   sum, dif;
    logic          fast;
    cia_pkg::res_t fast_res;
    logic [6:0]    lz_bits;
    logic [127:0]  prod;
    logic [63:0]   prod_signed;

    function automatic logic [63:0] sx(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int i = DATA_WIDTH; i < 64; i++) begin
            r[i] = v[DATA_WIDTH-1];
        end
        return r;
    endfunction

    function automatic logic [63:0] absv(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    assign a  = in_op.a;
    assign b  = in_op.b;
    assign ma = absv(a);
    assign mb = absv(b);
    assign sum = sx(a + b);
    assign dif = sx(a - b);

    always_comb begin
        lz_bits = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (ma[i]) begin
                lz_bits = 7'(i);
            end
        end
    end

    always_comb begin
        fast     = 1'b1;
        fast_res = '{value: 64'd0, err: cia_pkg::ERR_OK};
        case (in_op.mode)
            cia_pkg::MODE_ADD: begin
                if (a[63] == b[63] && sum[63] != a[63]) begin
                    fast_res.err = cia_pkg::ERR_OVF;
                end else begin
                    fast_res.value = sum;
                end
            end
            cia_pkg::MODE_SUB: begin
                if (a[63] != b[63] && dif[63] != a[63]) begin
                    fast_res.err = cia_pkg::ERR_OVF;
                end else begin
                    fast_res.value = dif;
                end
            end
            cia_pkg::MODE_MUL: begin
                fast = (ma == 64'd0) || (mb == 64'd0);
            end
            cia_pkg::MODE_DIV, cia_pkg::MODE_REM: begin
                if (b == 64'd0) begin
                    fast_res.err = cia_pkg::ERR_DIV0;
                end else if (b == '1) begin
                    if (in_op.mode == cia_pkg::MODE_DIV) begin
                        if (a == sx(HALF)) begin
                            fast_res.err = cia_pkg::ERR_OVF;
                        end else begin
                            fast_res.value = 64'd0 - a;
                        end
                    end
                end else begin
                    fast = 1'b0;
                end
            end
            cia_pkg::MODE_SHL: begin
                if (b[63]) begin
                    fast_res.err = cia_pkg::ERR_OVF;
                end else if (a != 64'd0) begin
                    if (b >= 64'(DATA_WIDTH - 1) - {57'd0, lz_bits}) begin
                        fast_res.err = cia_pkg::ERR_OVF;
                    end else begin
                        fast_res.value = sx(a << b[5:0]);
                    end
                end
            end
            cia_pkg::MODE_SHR: begin
                if (b[63]) begin
                    fast_res.err = cia_pkg::ERR_OVF;
                end else if (b >= 64'(DATA_WIDTH)) begin
                    fast_res.value = {64{a[63]}};
                end else begin
                    fast_res.value = $signed(a) >>> b[5:0];
                end
            end
            cia_pkg::MODE_AND: fast_res.value = a & b;
            cia_pkg::MODE_OR:  fast_res.value = a | b;
            cia_pkg::MODE_LT:  fast_res.value = {63'd0, $signed(a) < $signed(b)};
            cia_pkg::MODE_GT:  fast_res.value = {63'd0, $signed(a) > $signed(b)};
            cia_pkg::MODE_NE:  fast_res.value = {63'd0, a != b};
            cia_pkg::MODE_EQ:  fast_res.value = {63'd0, a == b};
            default: fast_res.value = 64'd0;
        endcase
    end

    assign in_ready  = (st_reg == ST_IDLE) && (!ovalid_reg || out_ready);
    assign div_start = in_valid && in_ready && !fast &&
                       (in_op.mode == cia_pkg::MODE_DIV || in_op.mode == cia_pkg::MODE_REM);
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;
    assign res_load  = (st_reg == ST_IDLE && in_valid && in_ready && fast) ||
                       (st_reg == ST_DIV && div_done) || (st_reg == ST_OUT);

    cia_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ma),
        .den     (mb),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_q),
        .rmd     (div_r)
    );

    assign prod = {64'd0, pp_reg[0]} + ({64'd0, pp_reg[1]} << 32) +
                  ({64'd0, pp_reg[2]} << 32) + ({64'd0, pp_reg[3]} << 64);
    assign prod_signed = neg_reg ? (64'd0 - prod[63:0]) : prod[63:0];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg  <= in_op;
            ma_reg  <= ma;
            mb_reg  <= mb;
            neg_reg <= a[63] ^ b[63];
        end
        if (st_reg == ST_MUL) begin
            pp_reg[mstep_reg] <= {32'd0, ma_reg[32*mstep_reg[0] +: 32]} *
                                 {32'd0, mb_reg[32*mstep_reg[1] +: 32]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            ovalid_reg <= 1'b0;
            mstep_reg  <= 2'd0;
        end else begin
            if (res_load) begin
                ovalid_reg <= 1'b1;
            end else if (out_valid && out_ready) begin
                ovalid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (in_valid && in_ready) begin
                        if (fast) begin
                            res_reg <= fast_res;
                        end else if (in_op.mode == cia_pkg::MODE_MUL) begin
                            st_reg    <= ST_MUL;
                            mstep_reg <= 2'd0;
                        end else begin
                            st_reg <= ST_DIV;
                        end
                    end
                end
                ST_MUL: begin
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3) begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        res_reg.err <= cia_pkg::ERR_OK;
                        if (op_reg.mode == cia_pkg::MODE_DIV) begin
                            res_reg.value <= neg_reg ? (64'd0 - div_q) : div_q;
                        end else begin
                            res_reg.value <= op_reg.a[63] ? (64'd0 - div_r) : div_r;
                        end
                        st_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (prod[127:64] != 64'd0 ||
                        prod[63:0] > (neg_reg ? HALF : HALF - 64'd1)) begin
                        res_reg <= '{value: 64'd0, err: cia_pkg::ERR_OVF};
                    end else begin
                        res_reg <= '{value: sx(prod_signed), err: cia_pkg::ERR_OK};
                    end
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> st_reg == ST_DIV)
        else $error("divider finished outside divide state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_DIV |-> div_busy || div_done)
        else $error("divide state without a running divider");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && res_reg.err != cia_pkg::ERR_OK |-> res_reg.value == 64'd0)
        else $error("error result not zero");

endmodule

/* sv/checked_integer_alu.sv */
// Checked signed integer ALU.
// Input channel s_axis_*: tdata holds mode [3:0], left_operand [67:4],
// right_operand [131:68], padded to 136 bits. Output channel m_axis_*:
// tdata holds result_value [63:0] and error_code [65:64], padded to 72 bits.
// Items are accepted when tvalid and tready are both high.
// A front register takes and sign-extends each item; a two-entry queue
// separates it from the execution part so either side may stall.
// Add, subtract, logic, shifts and compares are computed combinationally in the
// execute part: one item per cycle sustained while m_axis_tready stays high.
// Multiply forms four 32x32 partial products, then checks for overflow.
// Divide and remainder use a restoring divider of one bit per cycle and
// take no new item until it is done; by zero or by minus one they skip it.
// Results leave in input order. When the receiver holds m_axis_tready low
// the result register holds, then the queue and front register fill and
// s_axis_tready falls. aresetn (synchronous, active low) empties all stages.
module checked_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // mode, left_operand, right_operand
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // result_value, error_code
);

    logic          f_valid, f_ready;
    cia_pkg::op_t  f_op;
    logic          q_valid, q_ready;
    logic [131:0]  q_data;
    cia_pkg::res_t res;

    cia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tdata[3:0]),
        .in_a      (s_axis_tdata[67:4]),
        .in_b      (s_axis_tdata[131:68]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_op    (f_op)
    );

    cia_queue #(.WIDTH(132)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    cia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_op     (cia_pkg::op_t'(q_data)),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {6'd0, res.err, res.value};

endmodule

/* dv/checked_integer_alu_tb.sv */
module checked_integer_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  err;
    } alu_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    alu_result_t pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          quiet_phase = 1'b0;
    int          mode_hits[16];

    checked_integer_alu #(.DATA_WIDTH(64)) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] abs_full(logic signed [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic alu_result_t compute_alu(logic [3:0] mode, logic signed [63:0] a,
                                                logic signed [63:0] b);
        alu_result_t        r;
        logic signed [64:0] wide;
        logic signed [127:0] prod;
        logic [63:0]        mag;
        int                 bits;
        r.value = '0;
        r.err = cia_pkg::ERR_OK;
        case (mode)
            cia_pkg::MODE_ADD: begin
                wide = {a[63], a} + {b[63], b};
                if (wide[64] != wide[63]) r.err = cia_pkg::ERR_OVF;
                else r.value = wide[63:0];
            end
            cia_pkg::MODE_SUB: begin
                wide = {a[63], a} - {b[63], b};
                if (wide[64] != wide[63]) r.err = cia_pkg::ERR_OVF;
                else r.value = wide[63:0];
            end
            cia_pkg::MODE_MUL: begin
                prod = 128'(a) * 128'(b);
                if (prod != 128'(signed'(prod[63:0]))) r.err = cia_pkg::ERR_OVF;
                else r.value = prod[63:0];
            end
            cia_pkg::MODE_DIV: begin
                if (b == 0) r.err = cia_pkg::ERR_DIV0;
                else if (a == 64'sh8000_0000_0000_0000 && b == -1) r.err = cia_pkg::ERR_OVF;
                else r.value = a / b;
            end
            cia_pkg::MODE_REM: begin
                if (b == 0) r.err = cia_pkg::ERR_DIV0;
                else if (b == -1) r.value = '0;
                else r.value = a % b;
            end
            cia_pkg::MODE_SHL: begin
                if (b < 0) r.err = cia_pkg::ERR_OVF;
                else if (a != 0) begin
                    mag = abs_full(a);
                    bits = 0;
                    for (int i = 0; i < 64; i++) if (mag[i]) bits = i;
                    if (b >= 63 - bits) r.err = cia_pkg::ERR_OVF;
                    else r.value = a << b[5:0];
                end
            end
            cia_pkg::MODE_SHR: begin
                if (b < 0) r.err = cia_pkg::ERR_OVF;
                else r.value = a >>> ((b >= 64) ? 63 : b[5:0]);
            end
            cia_pkg::MODE_AND: r.value = a & b;
            cia_pkg::MODE_OR:  r.value = a | b;
            cia_pkg::MODE_LT:  r.value = 64'(a < b);
            cia_pkg::MODE_GT:  r.value = 64'(a > b);
            cia_pkg::MODE_NE:  r.value = 64'(a != b);
            cia_pkg::MODE_EQ:  r.value = 64'(a == b);
            default:  r.value = '0;
        endcase
        if (r.err != cia_pkg::ERR_OK) r.value = '0;
        return r;
    endfunction

    task automatic send_item(logic [3:0] mode, logic [63:0] a, logic [63:0] b);
        while (!quiet_phase && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a, mode};
        pending_results.push_back(compute_alu(mode, a, b));
        mode_hits[mode]++;
        items_sent++;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                alu_result_t want;
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result item %h", m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[63:0] !== want.value || m_axis_tdata[65:64] !== want.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected value %h err %0d, got value %h err %0d",
                                     want.value, want.err, m_axis_tdata[63:0],
                                     m_axis_tdata[65:64]);
                    end
                end
            end
            m_axis_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > 600000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'(signed'($urandom_range(20)) - 10);
            3: return {$urandom, $urandom} >> $urandom_range(63);
            4: return -({$urandom, $urandom} >> $urandom_range(63));
            5: return 64'(1) << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed_edges();
        logic [63:0] mn = 64'h8000_0000_0000_0000;
        logic [63:0] mx = 64'h7fff_ffff_ffff_ffff;
        send_item(cia_pkg::MODE_ADD, mx, 1);
        send_item(cia_pkg::MODE_ADD, mn, -1);
        send_item(cia_pkg::MODE_SUB, mn, 1);
        send_item(cia_pkg::MODE_SUB, 0, mn);
        send_item(cia_pkg::MODE_MUL, mn, -1);
        send_item(cia_pkg::MODE_MUL, mn, 1);
        send_item(cia_pkg::MODE_MUL, 64'h1_0000_0000, 64'h8000_0000);
        send_item(cia_pkg::MODE_DIV, 5, 0);
        send_item(cia_pkg::MODE_DIV, mn, -1);
        send_item(cia_pkg::MODE_DIV, -7, 2);
        send_item(cia_pkg::MODE_REM, 5, 0);
        send_item(cia_pkg::MODE_REM, mn, -1);
        send_item(cia_pkg::MODE_REM, -7, 2);
        send_item(cia_pkg::MODE_SHL, 1, -1);
        send_item(cia_pkg::MODE_SHL, 1, 62);
        send_item(cia_pkg::MODE_SHL, 1, 63);
        send_item(cia_pkg::MODE_SHL, mn, 0);
        send_item(cia_pkg::MODE_SHL, 0, 1000);
        send_item(cia_pkg::MODE_SHR, -1, -5);
        send_item(cia_pkg::MODE_SHR, mn, 200);
        send_item(cia_pkg::MODE_AND, mx, mn);
        send_item(cia_pkg::MODE_OR, mx, mn);
        send_item(cia_pkg::MODE_LT, mn, mx);
        send_item(cia_pkg::MODE_EQ, mx, mx);
        send_item(4'd15, mx, mx);
    endtask

    task automatic test_random_operations(int count);
        for (int i = 0; i < count; i++)
            send_item(4'($urandom_range(15)), pick_operand(), pick_operand());
    endtask

    task automatic test_back_to_back(int count);
        quiet_phase = 1'b1;
        for (int i = 0; i < count; i++)
            send_item(4'($urandom_range(12)), pick_operand(), pick_operand());
        quiet_phase = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_edges();
        test_random_operations(700);
        test_back_to_back(200);
        test_random_operations(500);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d items over all mode codes, %0d results checked.",
                 items_sent, results_seen);
        $display("Shift items: %0d left, %0d right; divide items: %0d.",
                 mode_hits[cia_pkg::MODE_SHL], mode_hits[cia_pkg::MODE_SHR],
                 mode_hits[cia_pkg::MODE_DIV]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* checked_integer_alu.f */
sv/cia_pkg.sv
sv/cia_queue.sv
sv/cia_front.sv
sv/cia_divider.sv
sv/cia_back.sv
sv/checked_integer_alu.sv
dv/checked_integer_alu_tb.sv
